// File: sv/rif_pkg.sv
package rif_pkg;

    // Result event codes
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_TXDONE     = 4'd1;
    localparam logic [3:0] EV_RXFRAME    = 4'd2;
    localparam logic [3:0] EV_DROPPED    = 4'd3;
    localparam logic [3:0] EV_RXSTART    = 4'd4;
    localparam logic [3:0] EV_CRCERR     = 4'd5;
    localparam logic [3:0] EV_CCADONE    = 4'd6;
    localparam logic [3:0] EV_CCABUSY    = 4'd7;
    localparam logic [3:0] EV_CCASTARTED = 4'd8;

    // Opcodes
    localparam logic OP_IRQ = 1'b0;
    localparam logic OP_CCA = 1'b1;

    // Interrupt status bit positions
    localparam int IRQ_TXDONE   = 0;
    localparam int IRQ_RXDONE   = 1;
    localparam int IRQ_PREAMBLE = 2;
    localparam int IRQ_SYNC     = 3;
    localparam int IRQ_HDROK    = 4;
    localparam int IRQ_HDRERR   = 5;
    localparam int IRQ_CRCERR   = 6;
    localparam int IRQ_CADDONE  = 7;
    localparam int IRQ_CADDET   = 8;

    // Frame types and destination address modes
    localparam logic [2:0] FT_BEACON   = 3'd0;
    localparam logic [2:0] FT_ACK      = 3'd2;
    localparam logic [1:0] AM_SHORT    = 2'd2;
    localparam logic [1:0] AM_LONG     = 2'd3;

    localparam logic [15:0] BCAST16 = 16'hFFFF;

    // Filter modes
    localparam logic [1:0] FM_FILTERED = 2'd0;
    localparam logic [1:0] FM_PROMISC  = 2'd1;
    localparam logic [1:0] FM_ACKONLY  = 2'd2;
    localparam logic [1:0] FM_UNUSED   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAN_ID     = 2'd0;
    localparam logic [1:0] CFG_SHORT_ID   = 2'd1;
    localparam logic [1:0] CFG_EXT_ID     = 2'd2;
    localparam logic [1:0] CFG_FILT_MODE  = 2'd3;

    typedef struct packed {
        logic [15:0] pan_id;
        logic [15:0] short_id;
        logic [63:0] ext_id;
        logic [1:0]  filter_mode;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [9:0]  irq_status;
        logic [15:0] frame_control;
        logic [15:0] dest_pan;
        logic [63:0] dest_addr;
    } item_t;

    typedef struct packed {
        logic receive_busy;
        logic medium_busy;
    } flags_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic       rearm_rx;
        flags_t     flags;
    } result_t;

endpackage

// File: sv/radio_irq_frame_filter_unit.sv
// Radio interrupt handler with an 802.15.4 destination address filter. Each
// transaction on the input channel is an interrupt event or a clear-channel
// request; exactly one result transaction follows it. The item is held in an
// input register and decoded into a result register, which offers its result;
// one item is taken every cycle while the output side keeps up; with the
// output stalled the block holds two items and then stalls its input. The
// receive-busy and medium-busy flags are updated as an item moves into the
// result register, so the next item sees them at once. Configuration
// registers (PAN id, short address, extended address, filter mode) are to be
// written through the plain write port while no transaction is in flight; the
// block does not enforce this. A write of the unused filter mode is ignored.
module radio_irq_frame_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [9:0]  irq_status,
    input  logic [15:0] frame_control,
    input  logic [15:0] dest_pan,
    input  logic [63:0] dest_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  event_res,
    output logic        rearm_rx,
    output logic        receive_busy_out,
    output logic        medium_busy_out
);
    import rif_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res_reg;
    result_t res_comb;
    logic    out_valid_reg;
    logic    out_valid_next;
    flags_t  flags_reg;
    flags_t  flags_next;
    logic    advance;
    logic    in_accept;

    rif_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rif_decode u_decode (
        .item   (item_reg),
        .cfg    (cfg),
        .flags  (flags_reg),
        .result (res_comb)
    );

    // advance the held item when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        flags_next     = advance ? res_comb.flags : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.opcode        <= opcode;
            item_reg.irq_status    <= irq_status;
            item_reg.frame_control <= frame_control;
            item_reg.dest_pan      <= dest_pan;
            item_reg.dest_addr     <= dest_addr;
        end
        if (advance)
            res_reg <= res_comb;
    end

    assign out_valid        = out_valid_reg;
    assign event_res        = res_reg.event_res;
    assign rearm_rx         = res_reg.rearm_rx;
    assign receive_busy_out = res_reg.flags.receive_busy;
    assign medium_busy_out  = res_reg.flags.medium_busy;

endmodule

// File: sv/rif_cfg.sv
module rif_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    output rif_pkg::cfg_t cfg
);
    import rif_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PAN_ID:     cfg_next.pan_id   = cfg_wdata[15:0];
                CFG_SHORT_ID:   cfg_next.short_id = cfg_wdata[15:0];
                CFG_EXT_ID:     cfg_next.ext_id   = cfg_wdata;
                CFG_FILT_MODE:
                begin
                    // drop writes of the unused mode
                    if (cfg_wdata[1:0] != FM_UNUSED)
                        cfg_next.filter_mode = cfg_wdata[1:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/rif_decode.sv
module rif_decode (
    input  rif_pkg::item_t   item,
    input  rif_pkg::cfg_t    cfg,
    input  rif_pkg::flags_t  flags,
    output rif_pkg::result_t result
);
    import rif_pkg::*;

    logic [2:0]  ftype;
    logic [1:0]  amode;
    logic        is_ack;
    logic        pan_ok;
    logic        addr_ok;
    logic        filt_pass;
    logic [9:0]  irq;

    assign irq    = item.irq_status;
    assign ftype  = item.frame_control[2:0];
    assign amode  = item.frame_control[11:10];
    assign is_ack = (ftype == FT_ACK);
    assign pan_ok = (item.dest_pan == BCAST16) || (item.dest_pan == cfg.pan_id);

    always_comb
    begin
        case (amode)
            AM_SHORT: addr_ok = (item.dest_addr[15:0] == cfg.short_id)
                             || (item.dest_addr[15:0] == BCAST16);
            AM_LONG:  addr_ok = (item.dest_addr == cfg.ext_id);
            default:  addr_ok = 1'b0;
        endcase
    end

    assign filt_pass = ((ftype == FT_BEACON) && (cfg.pan_id == BCAST16))
                    || (pan_ok && addr_ok);

    always_comb
    begin
        result.event_res = EV_NONE;
        result.rearm_rx  = 1'b0;
        result.flags     = flags;
        if (item.opcode == OP_CCA)
        begin
            if (flags.receive_busy)
                result.event_res = EV_CCABUSY;
            else
            begin
                result.flags.medium_busy = 1'b0;
                result.event_res         = EV_CCASTARTED;
            end
        end
        else
        begin
            result.flags.receive_busy = irq[IRQ_SYNC] | irq[IRQ_HDROK]
                                      | irq[IRQ_HDRERR] | irq[IRQ_CRCERR];
            if (irq[IRQ_TXDONE])
                result.event_res = EV_TXDONE;
            else if (irq[IRQ_RXDONE])
            begin
                result.flags.receive_busy = 1'b0;
                if (is_ack || ((cfg.filter_mode != FM_ACKONLY) && filt_pass)
                    || (cfg.filter_mode == FM_PROMISC))
                    result.event_res = EV_RXFRAME;
                else
                begin
                    result.event_res = EV_DROPPED;
                    result.rearm_rx  = 1'b1;
                end
            end
            else if (irq[IRQ_PREAMBLE] || irq[IRQ_SYNC])
                result.event_res = EV_NONE;
            else if (irq[IRQ_HDROK])
                result.event_res = EV_RXSTART;
            else if (irq[IRQ_HDRERR])
                result.event_res = EV_NONE;
            else if (irq[IRQ_CRCERR])
                result.event_res = EV_CRCERR;
            else if (irq[IRQ_CADDONE])
            begin
                if (irq[IRQ_CADDET])
                    result.flags.medium_busy = 1'b1;
                result.event_res = EV_CCADONE;
                result.rearm_rx  = 1'b1;
            end
        end
    end

endmodule

// File: sv/rif_checker.sv
module rif_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] event_res,
    input logic       rearm_rx,
    input logic       receive_busy_out,
    input logic       medium_busy_out
);
    import rif_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(rearm_rx))
        else $error("result changed while stalled");

    a_rearm_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rearm_rx |-> (event_res == EV_DROPPED || event_res == EV_CCADONE))
        else $error("rearm without drop or cad done");

    a_cca_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_CCASTARTED |-> !medium_busy_out && !receive_busy_out)
        else $error("cca started with busy flags set");

    a_cca_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_CCABUSY |-> receive_busy_out)
        else $error("cca busy without receive busy");

    a_rx_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_RXFRAME || event_res == EV_DROPPED)
            |-> !receive_busy_out)
        else $error("receive busy after frame end");

endmodule

bind radio_irq_frame_filter_unit rif_checker u_rif_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_res        (event_res),
    .rearm_rx         (rearm_rx),
    .receive_busy_out (receive_busy_out),
    .medium_busy_out  (medium_busy_out)
);
